/* rtl/hra_pkg.sv */
package hra_pkg;

  localparam int DATA_W         = 32;
  localparam int FRAC_W         = 24;
  localparam int TAU_W          = 26;
  localparam int LEN_W          = 6;
  localparam int POS_W          = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 26;
  localparam int PROD_W         = 2 * DATA_W + 1;
  localparam int RND_W          = PROD_W - FRAC_W;
  localparam int WIDE_W         = 64;
  localparam int MAX_LENGTH_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TAU_SCALE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = CFG_IDX_W'(1);

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_SEGMENT = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'({1'b1, {(FRAC_W-1){1'b0}}});
  localparam logic signed [WIDE_W-1:0] DATA_MAX = WIDE_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] DATA_MIN = ~DATA_MAX;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] updated_value;
    logic [POS_W-1:0]         position;
    logic                     last_of_segment;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic elem;
    logic drain_issue;
    logic drain_mode;
    logic clip_dot;
    logic coef_mul;
    logic coef_set;
    logic is_first;
    logic is_last;
  } hra_cmd_t;

  typedef struct packed {
    logic busy;
    logic adv;
  } hra_sts_t;

  typedef struct packed {
    logic                     clipped;
    logic signed [DATA_W-1:0] value;
  } clip_t;

  function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + (p[PROD_W-1] ? (RND_HALF - PROD_W'(1)) : RND_HALF);
    return s[PROD_W-1:FRAC_W];
  endfunction

  function automatic clip_t clip_data(input logic signed [WIDE_W-1:0] x);
    clip_t r;
    if (x > DATA_MAX) begin
      r.clipped = 1'b1;
      r.value   = DATA_MAX[DATA_W-1:0];
    end else if (x < DATA_MIN) begin
      r.clipped = 1'b1;
      r.value   = DATA_MIN[DATA_W-1:0];
    end else begin
      r.clipped = 1'b0;
      r.value   = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/hra_ctrl.sv */
module hra_ctrl #(
  parameter int  MAX_LENGTH = hra_pkg::MAX_LENGTH_DEF,
  localparam int CNT_W      = $clog2(MAX_LENGTH + 1),
  localparam int ADDR_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_action,
  output logic                       in_ready,
  input  logic                       len_we,
  input  logic [hra_pkg::LEN_W-1:0]  len_wdata,
  input  hra_pkg::hra_sts_t          sts,
  output hra_pkg::hra_cmd_t          cmd,
  output logic [ADDR_W-1:0]          addr
);

  localparam int LC_W = (CNT_W > hra_pkg::LEN_W) ? CNT_W : hra_pkg::LEN_W;

  typedef enum logic [6:0] {
    ST_COLLECT = 7'b0000001,
    ST_FLUSH   = 7'b0000010,
    ST_CLIP    = 7'b0000100,
    ST_CMUL    = 7'b0001000,
    ST_RND     = 7'b0010000,
    ST_COEF    = 7'b0100000,
    ST_DRAIN   = 7'b1000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [hra_pkg::LEN_W-1:0]  seglen_r;
  logic [CNT_W-1:0]           lcnt_r, lcnt_nxt, ecnt_r, ecnt_nxt, dcnt_r, dcnt_nxt;
  logic [LC_W-1:0]            len, lk, ek, dk, lk_inc, ek_inc, dk_inc;
  logic                       acc_item, load_acc, elem_acc, elem_last, drain_go;

  always_comb begin
    if (seglen_r == '0) begin
      len = LC_W'(1);
    end else if (LC_W'(seglen_r) > LC_W'(MAX_LENGTH)) begin
      len = LC_W'(MAX_LENGTH);
    end else begin
      len = LC_W'(seglen_r);
    end
    lk     = (LC_W'(lcnt_r) >= len) ? '0 : LC_W'(lcnt_r);
    ek     = (LC_W'(ecnt_r) >= len) ? '0 : LC_W'(ecnt_r);
    dk     = LC_W'(dcnt_r);
    lk_inc = lk + LC_W'(1);
    ek_inc = ek + LC_W'(1);
    dk_inc = dk + LC_W'(1);

    in_ready  = (state_r == ST_COLLECT);
    acc_item  = in_valid && in_ready;
    load_acc  = acc_item && (in_action == hra_pkg::ACT_LOAD);
    elem_acc  = acc_item && (in_action == hra_pkg::ACT_SEGMENT);
    elem_last = (ek_inc == len);
    drain_go  = (state_r == ST_DRAIN) && (dk < len) && sts.adv;
  end

  always_comb begin
    lcnt_nxt  = lcnt_r;
    ecnt_nxt  = ecnt_r;
    dcnt_nxt  = dcnt_r;
    state_nxt = state_r;
    if (load_acc) begin
      lcnt_nxt = (lk_inc >= len) ? '0 : lk_inc[CNT_W-1:0];
    end
    if (elem_acc) begin
      ecnt_nxt = elem_last ? '0 : ek_inc[CNT_W-1:0];
    end
    if (drain_go) begin
      dcnt_nxt = dk_inc[CNT_W-1:0];
    end
    unique case (state_r)
      ST_COLLECT: begin
        if (elem_acc && elem_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.busy) begin
          state_nxt = ST_CLIP;
        end
      end
      ST_CLIP:  state_nxt = ST_CMUL;
      ST_CMUL:  state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_COEF;
      ST_COEF: begin
        state_nxt = ST_DRAIN;
        dcnt_nxt  = '0;
      end
      ST_DRAIN: begin
        if ((dk >= len) && !sts.busy) begin
          state_nxt = ST_COLLECT;
        end
      end
      default:  state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.load        = load_acc;
    cmd.elem        = elem_acc;
    cmd.drain_issue = drain_go;
    cmd.drain_mode  = (state_r == ST_DRAIN);
    cmd.clip_dot    = (state_r == ST_CLIP);
    cmd.coef_mul    = (state_r == ST_CMUL);
    cmd.coef_set    = (state_r == ST_COEF);
    if (state_r == ST_DRAIN) begin
      addr         = dk[ADDR_W-1:0];
      cmd.is_first = (dk == '0);
      cmd.is_last  = (dk_inc == len);
    end else if (load_acc) begin
      addr         = lk[ADDR_W-1:0];
      cmd.is_first = (lk == '0);
      cmd.is_last  = 1'b0;
    end else begin
      addr         = ek[ADDR_W-1:0];
      cmd.is_first = (ek == '0);
      cmd.is_last  = elem_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_COLLECT;
      seglen_r <= hra_pkg::LEN_RESET;
      lcnt_r   <= '0;
      ecnt_r   <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lcnt_r  <= lcnt_nxt;
      ecnt_r  <= ecnt_nxt;
      dcnt_r  <= dcnt_nxt;
      if (len_we) begin
        seglen_r <= len_wdata;
      end
    end
  end

  a_clip_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLIP) |-> !sts.busy)
    else $error("coefficient formed while products still in flight");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (LC_W'(dcnt_r) <= len))
    else $error("drain index past segment length");

  a_last_to_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (elem_acc && elem_last) |=> (state_r == ST_FLUSH) && !in_ready)
    else $error("last element did not close the segment");

endmodule

/* rtl/hra_dpath.sv */
module hra_dpath #(
  parameter int  MAX_LENGTH = hra_pkg::MAX_LENGTH_DEF,
  localparam int ADDR_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hra_pkg::hra_cmd_t                 cmd,
  input  logic [ADDR_W-1:0]                 addr,
  input  logic signed [hra_pkg::DATA_W-1:0] in_value,
  input  logic                              tau_we,
  input  logic [hra_pkg::TAU_W-1:0]         tau_wdata,
  output hra_pkg::hra_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hra_pkg::out_item_t                out_data
);

  localparam int DW     = hra_pkg::DATA_W;
  localparam int PW     = hra_pkg::PROD_W;
  localparam int RW     = hra_pkg::RND_W;
  localparam int WW     = hra_pkg::WIDE_W;
  localparam int POS_W  = hra_pkg::POS_W;
  localparam int ACC_W  = 2 * DW - hra_pkg::FRAC_W + $clog2(MAX_LENGTH) + 2;
  localparam int PX_W   = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  logic signed [DW-1:0]      refl_mem [MAX_LENGTH];
  logic signed [DW-1:0]      seg_mem  [MAX_LENGTH];

  logic [hra_pkg::TAU_W-1:0] tau_r;
  logic signed [DW-1:0]      vrd_r, srd_r, elem1_r, x2_r, x3_r;
  logic                      v1_r, v2_r, v3_r;
  logic                      first1_r, first2_r, first3_r;
  logic                      last1_r, last2_r, last3_r;
  logic [POS_W-1:0]          pos1_r, pos2_r, pos3_r;
  logic signed [PW-1:0]      mul_r;
  logic signed [RW-1:0]      rnd_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DW-1:0]      dotc_r, coef_r;
  logic                      dclip_r, coefclip_r;
  logic                      out_valid_r;
  hra_pkg::out_item_t        out_data_r;

  logic                      out_free, en_pipe, load_out, sat_flag;
  logic signed [DW:0]        mul_a;
  logic signed [DW-1:0]      mul_b;
  logic signed [PW-1:0]      prod;
  logic signed [RW-1:0]      term;
  logic [PX_W-1:0]           pos_ext;
  hra_pkg::clip_t            dc, cc, dd;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    en_pipe  = !cmd.drain_mode || out_free;
    load_out = cmd.drain_mode && v3_r && en_pipe;

    if (cmd.coef_mul) begin
      mul_a = $signed((DW+1)'(tau_r));
    end else begin
      mul_a = (DW+1)'(vrd_r);
    end
    if (cmd.coef_mul) begin
      mul_b = dotc_r;
    end else if (cmd.drain_mode) begin
      mul_b = coef_r;
    end else begin
      mul_b = elem1_r;
    end
    prod = PW'(mul_a) * PW'(mul_b);

    term     = first3_r ? RW'(coef_r) : rnd_r;
    dc       = hra_pkg::clip_data(WW'(acc_r));
    cc       = hra_pkg::clip_data(WW'(rnd_r));
    dd       = hra_pkg::clip_data(WW'(x3_r) - WW'(term));
    sat_flag = (tau_r != '0) && (coefclip_r || dd.clipped);
    pos_ext  = PX_W'(addr);

    sts.busy = v1_r || v2_r || v3_r;
    sts.adv  = en_pipe;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      refl_mem[addr] <= in_value;
    end
    if (cmd.elem) begin
      seg_mem[addr] <= in_value;
    end
    if (cmd.elem || cmd.drain_issue) begin
      vrd_r <= refl_mem[addr];
    end
    if (cmd.drain_issue) begin
      srd_r <= seg_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tau_we) begin
        tau_r <= tau_wdata;
      end
      if (en_pipe) begin
        v1_r <= cmd.elem || cmd.drain_issue;
        v2_r <= v1_r;
        v3_r <= v2_r;
        if (v3_r && !cmd.drain_mode) begin
          acc_r <= first3_r ? ACC_W'(x3_r) : acc_r + ACC_W'(rnd_r);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      if (cmd.elem) begin
        elem1_r <= in_value;
      end
      first1_r <= cmd.is_first;
      last1_r  <= cmd.is_last;
      pos1_r   <= pos_ext[POS_W-1:0];
      mul_r    <= prod;
      x2_r     <= cmd.drain_mode ? srd_r : elem1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      pos2_r   <= pos1_r;
      rnd_r    <= hra_pkg::round_q(mul_r);
      x3_r     <= x2_r;
      first3_r <= first2_r;
      last3_r  <= last2_r;
      pos3_r   <= pos2_r;
    end
    if (cmd.clip_dot) begin
      dotc_r  <= dc.value;
      dclip_r <= dc.clipped;
    end
    if (cmd.coef_set) begin
      coef_r     <= cc.value;
      coefclip_r <= cc.clipped || dclip_r;
    end
    if (load_out) begin
      out_data_r <= '{updated_value:   dd.value,
                      position:        pos3_r,
                      last_of_segment: last3_r,
                      saturated:       sat_flag};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/householder_reflector_apply.sv */
// Reflector loads: one beat per cycle while collecting, no result.
// Segment elements: one beat per cycle while collecting; the dot product runs through
// a shared 33x32 multiplier, rounding and accumulate stages.
// After the last element beat: flush, clip the dot product, form, round and set the coefficient,
// then one result per cycle with out_ready high; no new beat is taken until the drain ends.
// Reset (rst_n low, synchronous): control, counters and output cleared, tau 0, length 1;
// reflector and segment stores hold no reset value and need no clearing pass.
module householder_reflector_apply #(
  parameter int MAX_LENGTH = hra_pkg::MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hra_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hra_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [hra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hra_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  hra_pkg::hra_cmd_t  cmd;
  hra_pkg::hra_sts_t  sts;
  logic [ADDR_W-1:0]  addr;
  logic               tau_we, len_we;

  always_comb begin
    tau_we = cfg_we && (cfg_index == hra_pkg::CFG_TAU_SCALE);
    len_we = cfg_we && (cfg_index == hra_pkg::CFG_SEGMENT_LENGTH);
  end

  hra_ctrl #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .len_we    (len_we),
    .len_wdata (cfg_wdata[hra_pkg::LEN_W-1:0]),
    .sts       (sts),
    .cmd       (cmd),
    .addr      (addr)
  );

  hra_dpath #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr      (addr),
    .in_value  (in_data.element_value),
    .tau_we    (tau_we),
    .tau_wdata (cfg_wdata[hra_pkg::TAU_W-1:0]),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_householder_reflector_apply.sv */
module tb_householder_reflector_apply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_LEN      = hra_pkg::MAX_LENGTH_DEF;
  localparam int          RANDOM_BEATS = 200;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          TAIL_CYCLES  = 30;
  localparam int          LIMIT_CYCLES = 300000;
  localparam longint      ACC_LIM      = longint'(1) << 61;
  localparam logic [31:0] TAU_ONE      = 32'h0100_0000;
  localparam logic [31:0] TAU_TWO      = 32'h0200_0000;
  localparam logic [31:0] TAU_TOP      = 32'h03FF_FFFF;

  localparam logic [hra_pkg::CFG_IDX_W-1:0] REG_TAU = hra_pkg::CFG_TAU_SCALE;
  localparam logic [hra_pkg::CFG_IDX_W-1:0] REG_LEN = hra_pkg::CFG_SEGMENT_LENGTH;

  typedef enum logic [1:0] {ROW_REG, ROW_LOAD, ROW_ELEM} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [hra_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [31:0]                   value;
    logic                          typed;
    hra_pkg::out_item_t            want;
  } row_t;

  localparam hra_pkg::out_item_t NO_WANT = '0;

  localparam row_t DIRECTED [29] = '{
    '{ROW_ELEM, REG_TAU, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 5'd0, 1'b1, 1'b0}},
    '{ROW_ELEM, REG_TAU, 32'h8000_0000, 1'b1, '{32'h8000_0000, 5'd0, 1'b1, 1'b0}},
    '{ROW_ELEM, REG_TAU, 32'h0000_0000, 1'b1, '{32'h0000_0000, 5'd0, 1'b1, 1'b0}},
    '{ROW_LOAD, REG_TAU, 32'h1234_5678, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0}},
    '{ROW_REG,  REG_TAU, TAU_ONE,       1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h4000_0000, 1'b1, '{32'h0000_0000, 5'd0, 1'b1, 1'b0}},
    '{ROW_REG,  REG_TAU, TAU_TWO,       1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 5'd0, 1'b1, 1'b1}},
    '{ROW_ELEM, REG_TAU, 32'h8000_0000, 1'b1, '{32'h0000_0000, 5'd0, 1'b1, 1'b1}},
    '{ROW_REG,  REG_TAU, TAU_TOP,       1'b0, NO_WANT},
    '{ROW_REG,  REG_LEN, 32'd0,         1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h0100_0000, 1'b0, NO_WANT},
    '{ROW_REG,  REG_TAU, 32'h0080_0000, 1'b0, NO_WANT},
    '{ROW_REG,  REG_LEN, 32'd4,         1'b0, NO_WANT},
    '{ROW_LOAD, REG_TAU, 32'hAAAA_AAAA, 1'b0, NO_WANT},
    '{ROW_LOAD, REG_TAU, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_LOAD, REG_TAU, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_LOAD, REG_TAU, 32'h0100_0000, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h0000_0001, 1'b0, NO_WANT},
    '{ROW_LOAD, REG_TAU, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h0080_0000, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'hFF00_0000, 1'b0, NO_WANT},
    '{ROW_REG,  REG_LEN, 32'd2,         1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'h0180_0000, 1'b0, NO_WANT},
    '{ROW_ELEM, REG_TAU, 32'hFE00_0000, 1'b0, NO_WANT}
  };

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  hra_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  hra_pkg::out_item_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [hra_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hra_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [hra_pkg::TAU_W-1:0] tau_reg;
  logic [hra_pkg::LEN_W-1:0] len_reg;
  longint                    refl_v [MAX_LEN];
  longint                    seg_a  [MAX_LEN];
  longint                    dot_acc;
  int unsigned               ld_idx;
  int unsigned               el_idx;

  hra_pkg::out_item_t updates_due [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned beats  = 0;
  int unsigned stall_left = 0;
  bit          quiet  = 1'b0;

  householder_reflector_apply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int unsigned eff_len(logic [hra_pkg::LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > MAX_LEN) return MAX_LEN;
    return int'(l);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (longint'(1) << (hra_pkg::FRAC_W - 1))) >>> hra_pkg::FRAC_W;
    if (m > ACC_LIM) m = ACC_LIM;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint acc_add(longint x, longint y);
    longint s;
    s = x + y;
    if (s > ACC_LIM) return ACC_LIM;
    if (s < -ACC_LIM) return -ACC_LIM;
    return s;
  endfunction

  function automatic longint clamp_word(longint x, inout bit hit);
    longint hi;
    hi = (longint'(1) << (hra_pkg::DATA_W - 1)) - 1;
    if (x > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (x < -hi - 1) begin
      hit = 1'b1;
      return -hi - 1;
    end
    return x;
  endfunction

  function automatic void absorb_beat(hra_pkg::in_item_t it);
    int unsigned        n;
    longint             v;
    longint             coef;
    longint             val;
    bit                 cclip;
    bit                 hit;
    hra_pkg::out_item_t r;
    n = eff_len(len_reg);
    v = longint'(it.element_value);
    if (it.action == hra_pkg::ACT_LOAD) begin
      if (ld_idx >= n) ld_idx = 0;
      refl_v[ld_idx] = v;
      ld_idx++;
      if (ld_idx >= n) ld_idx = 0;
      return;
    end
    if (el_idx >= n) begin
      el_idx  = 0;
      dot_acc = 0;
    end
    seg_a[el_idx] = v;
    dot_acc = (el_idx == 0) ? v : acc_add(dot_acc, qmul(refl_v[el_idx], v));
    el_idx++;
    if (el_idx < n) return;
    cclip = 1'b0;
    coef  = qmul(longint'(tau_reg), clamp_word(dot_acc, cclip));
    coef  = clamp_word(coef, cclip);
    for (int k = 0; k < n; k++) begin
      hit = 1'b0;
      if (tau_reg == 0) begin
        val = seg_a[k];
      end else begin
        hit = cclip;
        val = clamp_word(seg_a[k] - ((k == 0) ? coef : qmul(refl_v[k], coef)), hit);
      end
      r.updated_value   = val[hra_pkg::DATA_W-1:0];
      r.position        = hra_pkg::POS_W'(k);
      r.last_of_segment = (k + 1 == n);
      r.saturated       = hit;
      updates_due.push_back(r);
    end
    el_idx  = 0;
    dot_acc = 0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  task automatic send_beat(input logic act, input logic [31:0] val, input bit typed,
                           input hra_pkg::out_item_t want);
    hra_pkg::in_item_t it;
    int unsigned       gap;
    it.action        = act;
    it.element_value = val;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    absorb_beat(it);
    if (typed) updates_due[updates_due.size() - 1] = want;
    beats++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [hra_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (updates_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[hra_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == hra_pkg::CFG_TAU_SCALE) tau_reg = val[hra_pkg::TAU_W-1:0];
    else len_reg = val[hra_pkg::LEN_W-1:0];
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hra_pkg::out_item_t w;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (updates_due.size() == 0) begin
        flag_mismatch("unexpected result beat, value", out_data.updated_value, 0);
      end else begin
        w = updates_due.pop_front();
        if (out_data.updated_value !== w.updated_value)
          flag_mismatch("updated_value", out_data.updated_value, w.updated_value);
        if (out_data.position !== w.position)
          flag_mismatch("position", out_data.position, w.position);
        if (out_data.last_of_segment !== w.last_of_segment)
          flag_mismatch("last_of_segment", out_data.last_of_segment, w.last_of_segment);
        if (out_data.saturated !== w.saturated)
          flag_mismatch("saturated", out_data.saturated, w.saturated);
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned nseg;
    int unsigned base;
    logic [31:0] tau_pick;
    logic [31:0] len_pick;

    tau_reg = '0;
    len_reg = hra_pkg::LEN_RESET;
    dot_acc = 0;
    ld_idx  = 0;
    el_idx  = 0;
    foreach (refl_v[i]) begin
      refl_v[i] = 0;
      seg_a[i]  = 0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_REG:  write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
        ROW_LOAD: send_beat(hra_pkg::ACT_LOAD, DIRECTED[i].value, 1'b0, NO_WANT);
        default:  send_beat(hra_pkg::ACT_SEGMENT, DIRECTED[i].value, DIRECTED[i].typed,
                            DIRECTED[i].want);
      endcase
    end

    base = beats;
    while (beats - base < RANDOM_BEATS) begin
      case ($urandom_range(0, 6))
        0: tau_pick = 32'd0;
        1: tau_pick = TAU_ONE;
        2: tau_pick = TAU_TWO;
        3: tau_pick = TAU_TOP;
        4: tau_pick = $urandom_range(0, TAU_TOP);
        default: tau_pick = $urandom_range(0, TAU_TWO);
      endcase
      case ($urandom_range(0, 19))
        0: len_pick = 32'd0;
        1: len_pick = 32'd32;
        2: len_pick = $urandom_range(33, 63);
        3: len_pick = 32'd1;
        default: len_pick = $urandom_range(2, 8);
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(hra_pkg::CFG_TAU_SCALE, tau_pick);
        write_reg(hra_pkg::CFG_SEGMENT_LENGTH, len_pick);
      end else begin
        write_reg(hra_pkg::CFG_SEGMENT_LENGTH, len_pick);
        write_reg(hra_pkg::CFG_TAU_SCALE, tau_pick);
      end
      quiet = ($urandom_range(0, 3) == 0);
      n = eff_len(len_reg);
      repeat (n) send_beat(hra_pkg::ACT_LOAD, pick_value(), 1'b0, NO_WANT);
      nseg = (n > 8) ? 1 : $urandom_range(1, 4);
      repeat (nseg) begin
        repeat (n) begin
          if ($urandom_range(0, 19) == 0)
            send_beat(hra_pkg::ACT_LOAD, pick_value(), 1'b0, NO_WANT);
          send_beat(hra_pkg::ACT_SEGMENT, pick_value(), 1'b0, NO_WANT);
        end
      end
      // leave a partial segment behind for the next length change
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, n))
          send_beat(hra_pkg::ACT_SEGMENT, pick_value(), 1'b0, NO_WANT);
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    while (updates_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
